>>> hw/rtl/scr_pkg.sv
// Shared types, codes and geometry helpers for the scrolling text terminal.
`default_nettype none
package scr_pkg;

	localparam int CELLS_DEF  = 32;
	localparam int IDX_W      = 6;
	localparam int COL_W      = 5;
	localparam int ROW_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;

	localparam logic [1:0] CMD_HOME   = 2'd0;
	localparam logic [1:0] CMD_CHAR   = 2'd1;
	localparam logic [1:0] CMD_SETPOS = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	typedef enum logic [1:0] {
		OP_CHAR,
		OP_CR,
		OP_LF,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	// line length: zero reads as one, saturates at the store size
	function automatic logic [IDX_W-1:0] line_len(input logic [COL_W-1:0] cols,
		input int cells);
		logic [IDX_W-1:0] l;
		l = (cols == '0) ? IDX_W'(1) : IDX_W'(cols);
		if (int'(l) > cells) begin
			l = IDX_W'(cells);
		end
		return l;
	endfunction

	// whole lines only, never past the store's end
	function automatic logic [IDX_W-1:0] capacity(input logic [IDX_W-1:0] l,
		input logic [ROW_W-1:0] r, input int cells);
		logic [IDX_W+1:0] c2;
		logic [IDX_W+1:0] c3;
		logic [IDX_W-1:0] c;
		c2 = {1'b0, l, 1'b0};
		c3 = c2 + (IDX_W+2)'(l);
		if (r == 2'd3 && int'(c3) <= cells) begin
			c = IDX_W'(c3);
		end else if (r >= 2'd2 && int'(c2) <= cells) begin
			c = IDX_W'(c2);
		end else begin
			c = l;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/scr_in_if.sv
// Input channel: one character or clear per transaction.
`default_nettype none
interface scr_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] char_code;

	modport source (output valid, output func, output char_code, input ready);
	modport sink (input valid, input func, input char_code, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/scr_out_if.sv
// Output channel: one display command per transaction.
`default_nettype none
interface scr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] out_char;
	logic [4:0] position;
	logic       last;

	modport source (output valid, output command, output out_char, output position,
		output last, input ready);
	modport sink (input valid, input command, input out_char, input position,
		input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/scr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module scr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [$clog2(DEPTH)-1:0]  waddr,
	input  wire  [WIDTH-1:0]          wdata,
	input  wire                       re,
	input  wire  [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/scr_front.sv
// Front end: accepts input transactions, classifies them and queues them.
`default_nettype none
module scr_front (
	input  wire              clk,
	input  wire              arst_n,
	scr_in_if.sink           in_ch,
	output scr_pkg::qhead_t  head,
	input  wire              pop
);
	localparam int QDEPTH = 2;

	scr_pkg::item_t fifo_q [QDEPTH];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;
	scr_pkg::item_t item_in;
	logic           push;

	always_comb begin
		item_in.ch = in_ch.char_code;
		if (in_ch.func) begin
			item_in.op = scr_pkg::OP_CLEAR;
		end else if (in_ch.char_code == scr_pkg::CH_CR) begin
			item_in.op = scr_pkg::OP_CR;
		end else if (in_ch.char_code == scr_pkg::CH_LF) begin
			item_in.op = scr_pkg::OP_LF;
		end else begin
			item_in.op = scr_pkg::OP_CHAR;
		end
	end

	assign in_ch.ready = (cnt_q != 2'(QDEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign head.valid  = (cnt_q != 2'd0);
	assign head.item   = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop && head.valid) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop && head.valid})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/scr_back.sv
// Back end: line store, insert point and cursor tracking, command sequencer.
`default_nettype none
module scr_back #(
	parameter int CELLS = scr_pkg::CELLS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  scr_pkg::qhead_t                   head,
	output logic                              pop,
	input  wire                               cfg_wr_en,
	input  wire  [scr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [scr_pkg::CFG_DATA_W-1:0]    cfg_data,
	scr_out_if.source                         out_ch
);
	localparam int AW = $clog2(CELLS);
	localparam int IW = scr_pkg::IDX_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLR    = 4'd1;
	localparam logic [3:0] S_HOME   = 4'd2;
	localparam logic [3:0] S_RDA    = 4'd3;
	localparam logic [3:0] S_RDB    = 4'd4;
	localparam logic [3:0] S_RDN    = 4'd5;
	localparam logic [3:0] S_SETPOS = 4'd6;
	localparam logic [3:0] S_CHAR   = 4'd7;
	localparam logic [3:0] S_CR     = 4'd8;

	logic [scr_pkg::COL_W-1:0] cols_q;
	logic [scr_pkg::ROW_W-1:0] rows_q;
	logic [IW-1:0]             ip_q;
	logic [IW-1:0]             le_q;
	logic                      full_q;
	logic [IW-1:0]             cursor_q;
	logic [CELLS-1:0]          valid_q;
	logic [3:0]                state_q;
	logic [IW-1:0]             idx_q;
	logic                      pend_q;
	logic [7:0]                ch_q;

	logic                      rd_valid_s1;
	logic                      rd_last_s1;
	logic                      rd_hit_s1;
	logic [7:0]                rdata;

	logic                      out_valid_q;
	logic [1:0]                out_cmd_q;
	logic [7:0]                out_char_q;
	logic [4:0]                out_pos_q;
	logic                      out_last_q;

	logic [IW-1:0]             ll;
	logic [IW-1:0]             cap;
	logic [IW-1:0]             home_pos;
	logic [scr_pkg::COL_W-1:0] cols_n;
	logic [IW-1:0]             ll_n;
	logic                      can_load;
	logic                      direct_ok;
	logic                      issue_ok;
	logic                      rd_issue;
	logic                      rd_last;
	logic                      emit;
	logic [1:0]                emit_cmd;
	logic [7:0]                emit_char;
	logic [4:0]                emit_pos;
	logic                      emit_last;
	logic                      wrap;
	logic [IW-1:0]             nl_ip;
	logic [IW-1:0]             nl_le;
	logic [IW-1:0]             cr_back;
	logic                      ram_we;

	assign ll       = scr_pkg::line_len(cols_q, CELLS);
	assign cap      = scr_pkg::capacity(ll, rows_q, CELLS);
	assign home_pos = cap - ll;
	assign cols_n   = (cfg_index == scr_pkg::REG_COLUMNS) ? cfg_data : cols_q;
	assign ll_n     = scr_pkg::line_len(cols_n, CELLS);

	assign can_load  = !out_valid_q || out_ch.ready;
	assign direct_ok = can_load && !rd_valid_s1;
	assign issue_ok  = !rd_valid_s1 || can_load;

	assign wrap    = (le_q >= cap);
	assign nl_ip   = wrap ? '0 : le_q;
	assign nl_le   = nl_ip + ll;
	assign cr_back = ll - (le_q - ip_q);

	assign pop = (state_q == S_IDLE) && head.valid && !cfg_wr_en;

	always_comb begin
		rd_issue = 1'b0;
		rd_last  = 1'b0;
		case (state_q)
			S_RDA: rd_issue = issue_ok && (idx_q != cap);
			S_RDB: rd_issue = issue_ok && (idx_q != le_q);
			S_RDN: begin
				rd_issue = issue_ok && (idx_q != ip_q);
				rd_last  = (IW'(idx_q + 1'b1) == ip_q) && !pend_q;
			end
			default: rd_issue = 1'b0;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_cmd  = scr_pkg::CMD_HOME;
		emit_char = 8'd0;
		emit_pos  = 5'd0;
		emit_last = 1'b0;
		case (state_q)
			S_CLR: begin
				emit     = direct_ok;
				emit_cmd = scr_pkg::CMD_CLEAR;
			end
			S_HOME: begin
				emit      = direct_ok;
				emit_cmd  = scr_pkg::CMD_HOME;
				emit_last = !full_q && (ip_q == '0) && !pend_q;
			end
			S_SETPOS: begin
				emit      = direct_ok;
				emit_cmd  = scr_pkg::CMD_SETPOS;
				emit_pos  = home_pos[4:0];
				emit_last = !pend_q;
			end
			S_CHAR: begin
				emit      = direct_ok;
				emit_cmd  = scr_pkg::CMD_CHAR;
				emit_char = ch_q;
				emit_last = 1'b1;
			end
			S_CR: begin
				emit      = direct_ok;
				emit_cmd  = scr_pkg::CMD_SETPOS;
				emit_pos  = cursor_q[4:0];
				emit_last = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	assign ram_we = emit && (state_q == S_CHAR) && (int'(ip_q) < CELLS);

	scr_ram #(
		.WIDTH (8),
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ip_q[AW-1:0]),
		.wdata (ch_q),
		.re    (rd_issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q      <= scr_pkg::COL_W'(16);
			rows_q      <= scr_pkg::ROW_W'(2);
			ip_q        <= '0;
			le_q        <= scr_pkg::line_len(scr_pkg::COL_W'(16), CELLS);
			full_q      <= 1'b0;
			cursor_q    <= '0;
			valid_q     <= '0;
			state_q     <= S_IDLE;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (rd_valid_s1 && can_load) begin
				out_valid_q <= 1'b1;
			end else if (emit) begin
				out_valid_q <= 1'b1;
			end
			if (can_load) begin
				rd_valid_s1 <= 1'b0;
			end
			if (rd_issue) begin
				rd_valid_s1 <= 1'b1;
				idx_q       <= IW'(idx_q + 1'b1);
				cursor_q    <= IW'(cursor_q + 1'b1);
			end

			if (cfg_wr_en) begin
				case (cfg_index)
					scr_pkg::REG_COLUMNS: cols_q <= cfg_data;
					scr_pkg::REG_ROWS:    rows_q <= cfg_data[scr_pkg::ROW_W-1:0];
					default:              cols_q <= cols_q;
				endcase
				valid_q  <= '0;
				ip_q     <= '0;
				le_q     <= ll_n;
				full_q   <= 1'b0;
				cursor_q <= '0;
			end else if (pop) begin
				case (head.item.op)
					scr_pkg::OP_CLEAR: begin
						valid_q  <= '0;
						ip_q     <= '0;
						le_q     <= ll;
						full_q   <= 1'b0;
						cursor_q <= '0;
						pend_q   <= 1'b0;
						state_q  <= S_CLR;
					end
					scr_pkg::OP_CR: begin
						ip_q     <= le_q - ll;
						cursor_q <= cursor_q - cr_back;
						state_q  <= S_CR;
					end
					default: begin
						if (head.item.op == scr_pkg::OP_LF || ip_q == le_q) begin
							ip_q    <= nl_ip;
							le_q    <= nl_le;
							full_q  <= full_q | wrap;
							pend_q  <= (head.item.op == scr_pkg::OP_CHAR);
							state_q <= S_HOME;
							for (int i = 0; i < CELLS; i++) begin
								if (IW'(i) >= nl_ip && IW'(i) < nl_le) begin
									valid_q[i] <= 1'b0;
								end
							end
						end else begin
							pend_q  <= 1'b0;
							state_q <= S_CHAR;
						end
					end
				endcase
			end else begin
				case (state_q)
					S_CLR: begin
						if (emit) begin
							state_q <= S_HOME;
						end
					end
					S_HOME: begin
						if (emit) begin
							cursor_q <= '0;
							if (full_q) begin
								idx_q   <= le_q;
								state_q <= S_RDA;
							end else begin
								idx_q   <= '0;
								state_q <= S_RDN;
							end
						end
					end
					S_RDA: begin
						if (idx_q == cap) begin
							idx_q   <= '0;
							state_q <= S_RDB;
						end
					end
					S_RDB: begin
						if (idx_q == le_q) begin
							state_q <= S_SETPOS;
						end
					end
					S_RDN: begin
						if (idx_q == ip_q) begin
							state_q <= pend_q ? S_CHAR : S_IDLE;
						end
					end
					S_SETPOS: begin
						if (emit) begin
							cursor_q <= home_pos;
							state_q  <= pend_q ? S_CHAR : S_IDLE;
						end
					end
					S_CHAR: begin
						if (emit) begin
							valid_q[ip_q[AW-1:0]] <= 1'b1;
							ip_q     <= IW'(ip_q + 1'b1);
							cursor_q <= IW'(cursor_q + 1'b1);
							state_q  <= S_IDLE;
						end
					end
					S_CR: begin
						if (emit) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ch_q <= head.item.ch;
		end
		if (rd_issue) begin
			rd_last_s1 <= rd_last;
			rd_hit_s1  <= valid_q[idx_q[AW-1:0]];
		end
		if (rd_valid_s1 && can_load) begin
			out_cmd_q  <= scr_pkg::CMD_CHAR;
			out_char_q <= rd_hit_s1 ? rdata : scr_pkg::CH_SPACE;
			out_pos_q  <= 5'd0;
			out_last_q <= rd_last_s1;
		end else if (emit) begin
			out_cmd_q  <= emit_cmd;
			out_char_q <= emit_char;
			out_pos_q  <= emit_pos;
			out_last_q <= emit_last;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.command  = out_cmd_q;
	assign out_ch.out_char = out_char_q;
	assign out_ch.position = out_pos_q;
	assign out_ch.last     = out_last_q;
endmodule
`default_nettype wire

>>> hw/rtl/scrolling_text_terminal.sv
// Scrolling text terminal: top level joining front end, queue and back end.
//
// in_ch takes one transaction per character or clear (func = 1). out_ch returns the
// display commands for it, one per transaction, with last set on the final one.
// Configuration (columns, rows) is written through cfg_wr_en / cfg_index /
// cfg_data while the block is idle; a write blanks the line store.
// An item leaves the two-entry queue when the sequencer is idle and no configuration
// write is present. Plain characters give one command, or open a new line first when
// the line is full; carriage returns give one command. A new line gives cursor home,
// one write per stored cell (up to CELLS) and a set-position when wrapped, one
// command per cycle while the receiver does not stall, pausing after each pass over
// the store, paced by the store's single read port.
// The next queued transaction is taken once the sequencer is back to idle.
// Reset: columns 16, rows 2, empty store reading as spaces, cursor at zero;
// no clearing pass is needed, valid bits cover the store.
// When the receiver stalls, the command register holds and the sequencer waits;
// the front end keeps accepting until its queue is full.
`default_nettype none
module scrolling_text_terminal #(
	parameter int CELLS = scr_pkg::CELLS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	scr_in_if.sink                         in_ch,
	scr_out_if.source                      out_ch,
	input  wire                            cfg_wr_en,
	input  wire  [scr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [scr_pkg::CFG_DATA_W-1:0] cfg_data
);
	scr_pkg::qhead_t q_head;
	logic            q_pop;

	scr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.head   (q_head),
		.pop    (q_pop)
	);

	scr_back #(
		.CELLS (CELLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ch    (out_ch)
	);

	a_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q_head.valid && !q_pop |=> q_head.valid)
		else $error("queued transaction lost");

	a_clear_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.command == scr_pkg::CMD_CLEAR |-> !out_ch.last)
		else $error("clear display marked as final command");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.command != scr_pkg::CMD_SETPOS |-> out_ch.position == 5'd0)
		else $error("position set on non set-position command");
endmodule
`default_nettype wire

>>> verif/tb_scrolling_text_terminal.sv
// Self-checking testbench for the scrolling text terminal with display command prediction.
`default_nettype none
module tb_scrolling_text_terminal;
	import scr_pkg::*;

	localparam int CELLS = CELLS_DEF;
	localparam int unsigned CYCLE_LIMIT = 1_500_000;

	typedef struct {
		logic [1:0] command;
		logic [7:0] ch;
		logic [4:0] pos;
		logic       last;
	} disp_cmd_t;

	// tracks the line store and cursor, holds the display commands still due
	class screen_tracker;
		logic [7:0] text [CELLS];
		logic [5:0] ins_at;
		logic [5:0] line_stop;
		logic [5:0] cur;
		bit         wrapped;
		logic [4:0] cols;
		logic [1:0] rws;
		disp_cmd_t  burst[$];
		disp_cmd_t  due[$];
		int         errors;

		function int unsigned line_cells();
			int unsigned l;
			l = (cols == 0) ? 1 : cols;
			if (l > CELLS) begin
				l = CELLS;
			end
			return l;
		endfunction

		// whole lines only
		function int unsigned store_cells();
			int unsigned l;
			int unsigned c;
			int unsigned m;
			l = line_cells();
			c = l * ((rws == 0) ? 1 : rws);
			m = (CELLS / l) * l;
			return (c > m) ? m : c;
		endfunction

		function void blank();
			foreach (text[i]) begin
				text[i] = CH_SPACE;
			end
			ins_at = 0;
			line_stop = 6'(line_cells());
			wrapped = 0;
			cur = 0;
		endfunction

		function void power_up();
			cols = 5'd16;
			rws = 2'd2;
			errors = 0;
			blank();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_COLUMNS) begin
				cols = data[4:0];
			end else begin
				rws = data[1:0];
			end
			blank();
		endfunction

		function void emit(logic [1:0] cmd, logic [7:0] ch, logic [4:0] pos);
			disp_cmd_t d;
			d.command = cmd;
			d.ch = ch;
			d.pos = pos;
			d.last = 1'b0;
			burst.push_back(d);
		endfunction

		function void show_cell(int unsigned i);
			emit(CMD_CHAR, (i < CELLS) ? text[i] : CH_SPACE, 5'd0);
			cur = cur + 6'd1;
		endfunction

		function void redraw();
			int unsigned c;
			c = store_cells();
			emit(CMD_HOME, 8'd0, 5'd0);
			cur = 0;
			if (wrapped) begin
				for (int unsigned i = line_stop; i < c; i++) show_cell(i);
				for (int unsigned i = 0; i < line_stop; i++) show_cell(i);
				cur = 6'(c - line_cells());
				emit(CMD_SETPOS, 8'd0, cur[4:0]);
			end else begin
				for (int unsigned i = 0; i < ins_at; i++) show_cell(i);
			end
		endfunction

		function void open_line();
			int unsigned l;
			l = line_cells();
			ins_at = line_stop;
			if (ins_at >= store_cells()) begin
				wrapped = 1;
				ins_at = 0;
			end
			line_stop = ins_at + 6'(l);
			for (int unsigned i = ins_at; i < line_stop; i++) begin
				if (i < CELLS) text[i] = CH_SPACE;
			end
			redraw();
		endfunction

		function void take_input(logic f, logic [7:0] c);
			int unsigned back;
			burst.delete();
			if (f) begin
				blank();
				emit(CMD_CLEAR, 8'd0, 5'd0);
				redraw();
			end else if (c == CH_CR) begin
				back = line_cells() - (line_stop - ins_at);
				ins_at = line_stop - 6'(line_cells());
				cur = cur - 6'(back);
				emit(CMD_SETPOS, 8'd0, cur[4:0]);
			end else if (c == CH_LF) begin
				open_line();
			end else begin
				if (ins_at == line_stop) open_line();
				if (ins_at < CELLS) text[ins_at] = c;
				ins_at = ins_at + 6'd1;
				emit(CMD_CHAR, c, 5'd0);
				cur = cur + 6'd1;
			end
			burst[burst.size()-1].last = 1'b1;
			foreach (burst[i]) begin
				due.push_back(burst[i]);
			end
		endfunction

		function void field_ok(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_cmd(logic [1:0] cmd, logic [7:0] ch, logic [4:0] pos,
			logic last);
			disp_cmd_t d;
			if (due.size() == 0) begin
				$display("%0t: unexpected command, expected none, actual %0d", $time, cmd);
				errors++;
				return;
			end
			d = due.pop_front();
			field_ok("command", 8'(d.command), 8'(cmd));
			field_ok("out_char", d.ch, ch);
			field_ok("position", 8'(d.pos), 8'(pos));
			field_ok("last", 8'(d.last), 8'(last));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	scr_in_if in_bus();
	scr_out_if out_bus();

	screen_tracker scoreboard;
	int unsigned cycles;
	int hold_req;
	bit hold_taken;
	int hold_left;
	int stall_left;
	bit send_idle;
	bit take_idle;

	scrolling_text_terminal dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_bus),
		.out_ch(out_bus),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_scrolling_text_terminal: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_bus.valid && in_bus.ready) begin
				scoreboard.take_input(in_bus.func, in_bus.char_code);
			end
			if (out_bus.valid && out_bus.ready) begin
				scoreboard.check_cmd(out_bus.command, out_bus.out_char, out_bus.position,
					out_bus.last);
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	initial begin
		out_bus.ready <= 1'b0;
		hold_taken = 1'b0;
		hold_left = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0 && !hold_taken) begin
				hold_left = hold_req;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				out_bus.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				out_bus.ready <= 1'b1;
				if (take_idle && $urandom_range(0, 7) == 0) stall_left = gap_len();
			end
		end
	end

	task automatic send_item(logic f, logic [7:0] c);
		int gap;
		gap = (send_idle && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.func <= f;
		in_bus.char_code <= c;
		do @(posedge clk); while (!in_bus.ready);
	endtask

	task automatic send_random();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			send_item(1'b1, 8'($urandom));
		end else if (r < 11) begin
			send_item(1'b0, CH_LF);
		end else if (r < 18) begin
			send_item(1'b0, CH_CR);
		end else begin
			send_item(1'b0, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		scoreboard.write_reg(idx, data);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits on the rows write are don't-care
	task automatic set_geometry(logic [4:0] c, logic [1:0] r);
		write_cfg(REG_COLUMNS, c);
		write_cfg(REG_ROWS, {3'($urandom), r});
	endtask

	task automatic wait_idle();
		in_bus.valid <= 1'b0;
		do @(posedge clk); while (scoreboard.due.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		int ph_cols [10];
		int ph_rows [10];
		ph_cols = '{16, 1, 31, 0, 2, 5, 11, 16, 20, 3};
		ph_rows = '{2, 1, 3, 0, 3, 3, 3, 3, 2, 1};
		scoreboard = new();
		scoreboard.power_up();
		hold_req = 0;
		send_idle = 1'b1;
		take_idle = 1'b1;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_COLUMNS;
		cfg_data <= '0;
		in_bus.valid <= 1'b0;
		in_bus.func <= 1'b0;
		in_bus.char_code <= 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hff);
		send_item(1'b0, CH_CR);
		send_item(1'b0, CH_LF);
		send_item(1'b0, 8'h41);
		send_item(1'b1, 8'h00);
		send_item(1'b1, 8'hff);
		wait_idle();

		// two-cell lines, three rows: overflow then wrap
		set_geometry(5'd2, 2'd3);
		for (int i = 0; i < 7; i++) send_item(1'b0, 8'h61 + 8'(i));
		send_item(1'b0, CH_CR);
		send_item(1'b0, CH_LF);
		send_item(1'b0, 8'h68);
		send_item(1'b1, 8'h0d);
		wait_idle();

		set_geometry(5'd0, 2'd0);
		send_item(1'b0, 8'h71);
		send_item(1'b0, 8'h72);
		send_item(1'b0, CH_LF);
		send_item(1'b0, CH_CR);
		wait_idle();

		for (int p = 0; p < 10; p++) begin
			if (p == 9) begin
				ph_cols[p] = $urandom_range(0, 31);
				ph_rows[p] = $urandom_range(0, 3);
			end
			set_geometry(5'(ph_cols[p]), 2'(ph_rows[p]));
			send_idle = (p != 0 && p != 4);
			take_idle = (p != 4);
			if (p == 0) hold_req = 300;
			repeat (25) send_random();
			wait_idle();
		end

		if (scoreboard.errors == 0) begin
			$display("tb_scrolling_text_terminal: clean");
		end else begin
			$display("tb_scrolling_text_terminal: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
